// ----- rtl/core/bitmap_text_layout_defines.svh -----
// Assertion macros used by the checker of the text layout block.
`ifndef BITMAP_TEXT_LAYOUT_DEFINES_SVH
`define BITMAP_TEXT_LAYOUT_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define BTL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("btl assertion failed");

// Next-cycle implication, off while reset is high.
`define BTL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("btl assertion failed");

// Next-cycle implication that also holds across reset.
`define BTL_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("btl assertion failed");

`endif

// ----- rtl/core/btl_pkg.sv -----
`timescale 1ns / 1ps
package btl_pkg;

   localparam logic [2:0] CSR_ORIGIN_X    = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_Y    = 3'd1;
   localparam logic [2:0] CSR_BASE_COLOR  = 3'd2;
   localparam logic [2:0] CSR_FIRST_CODE  = 3'd3;
   localparam logic [2:0] CSR_GLYPH_COUNT = 3'd4;
   localparam logic [2:0] CSR_LINE_HEIGHT = 3'd5;
   localparam logic [2:0] CSR_CELL_WIDTH  = 3'd6;
   localparam logic [2:0] CSR_KERN        = 3'd7;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
   localparam logic [7:0] CHAR_TILDE   = 8'h7e;

   localparam int PALETTE_SIZE = 36;

   localparam logic [31:0] PALETTE [PALETTE_SIZE] = '{
      32'hffffffff, 32'h0000a8ff, 32'h00a800ff, 32'ha80000ff, 32'h006060ff,
      32'ha800a8ff, 32'hf8a800ff, 32'h808080ff, 32'h505050ff, 32'h0000f8ff,
      32'h00f800ff, 32'h00f8f8ff, 32'hf80000ff, 32'hf800f8ff, 32'hf8f800ff,
      32'h000000ff, 32'ha8a8a8ff, 32'hf88080ff, 32'h80f880ff, 32'hb0b0f8ff,
      32'h00d0d0ff, 32'hf880f8ff, 32'hf8f880ff, 32'hf8c870ff, 32'h805010ff,
      32'hf868b0ff, 32'hf8b8d0ff, 32'hf84068ff, 32'h4880b8ff, 32'h00a0a0ff,
      32'h303030ff, 32'hf0f0e0ff, 32'h8080a0ff, 32'h704838ff, 32'h80a080ff,
      32'hb02050ff
   };

   typedef struct packed {
      logic [15:0] origin_x;
      logic [15:0] origin_y;
      logic [31:0] base_color;
      logic [7:0]  first_code;
      logic [8:0]  glyph_count;
      logic [7:0]  line_height;
      logic [7:0]  cell_width;
      logic [7:0]  kern;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      origin_x:    16'h0000,
      origin_y:    16'h0000,
      base_color:  32'hffffffff,
      first_code:  8'd32,
      glyph_count: 9'd0,
      line_height: 8'd16,
      cell_width:  8'd8,
      kern:        8'h00
   };

   // Decoded text character on its way to the pen stage.
   typedef struct packed {
      logic        sot;
      logic        last;
      logic        is_newline;
      logic        is_tilde;
      logic        slot_ok;
      logic        slot_zero;
      logic [31:0] pal_color;
      logic        hit;
      logic [7:0]  glyph;
   } char_type;

   function automatic logic slot_valid(input logic [7:0] ch);
      return (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h61 && ch <= 8'h7a) ||
             (ch >= 8'h41 && ch <= 8'h5a);
   endfunction

   function automatic logic [5:0] slot_of(input logic [7:0] ch);
      logic [7:0] s;
      if (ch <= 8'h39) begin
         s = ch - 8'h30;
      end else if (ch >= 8'h61) begin
         s = ch - 8'h61 + 8'd10;
      end else begin
         s = ch - 8'h41 + 8'd10;
      end
      return s[5:0];
   endfunction

endpackage

// ----- rtl/core/btl_glyph_mem.sv -----
`timescale 1ns / 1ps
module btl_glyph_mem #(
   parameter int GLYPHS     = 256,
   parameter int WIDTH_BITS = 8,
   parameter int IDX_W      = 8
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [IDX_W-1:0]      wr_addr,
   input  logic [WIDTH_BITS-1:0] wr_width,
   input  logic [WIDTH_BITS-1:0] wr_offset,
   input  logic                  rd_en,
   input  logic [IDX_W-1:0]      rd_addr,
   output logic [WIDTH_BITS-1:0] rd_width,
   output logic [WIDTH_BITS-1:0] rd_offset
);

   logic [2*WIDTH_BITS-1:0] glyph_mem_ff [GLYPHS];
   logic [2*WIDTH_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         glyph_mem_ff[wr_addr] <= {wr_width, wr_offset};
      end
   end

   // Hold the read word until the next text beat is taken.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= glyph_mem_ff[rd_addr];
      end
   end

   assign rd_width  = rd_data_ff[2*WIDTH_BITS-1:WIDTH_BITS];
   assign rd_offset = rd_data_ff[WIDTH_BITS-1:0];

endmodule

// ----- rtl/core/btl_pen.sv -----
`timescale 1ns / 1ps
module btl_pen
   import btl_pkg::*;
#(
   parameter int WIDTH_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  item_valid,
   input  char_type              item,
   input  logic [WIDTH_BITS-1:0] rd_width,
   input  logic [WIDTH_BITS-1:0] rd_offset,
   output logic                  ready,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_glyph,
   output logic signed [15:0]    rsp_draw_x,
   output logic signed [15:0]    rsp_draw_y,
   output logic [31:0]           rsp_color
);

   logic [15:0] pen_x_ff, pen_x_in;
   logic [15:0] pen_y_ff, pen_y_in;
   logic [31:0] color_ff, color_in;
   logic        tilde_ff, tilde_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  glyph_ff, glyph_in;
   logic [15:0] draw_x_ff, draw_x_in;
   logic [15:0] draw_y_ff, draw_y_in;
   logic [31:0] out_color_ff, out_color_in;

   logic        advance;
   logic [15:0] kern_ext;

   assign ready    = !rsp_valid_ff || !rsp_stall;
   assign advance  = item_valid && ready;
   assign kern_ext = {{8{cfg.kern[7]}}, cfg.kern};

   always_comb begin
      logic [15:0] px;
      logic [15:0] py;
      logic [31:0] col;
      logic        plain;
      logic        emit;

      px    = item.sot ? cfg.origin_x : pen_x_ff;
      py    = item.sot ? cfg.origin_y : pen_y_ff;
      col   = item.sot ? cfg.base_color : color_ff;
      plain = 1'b0;
      emit  = 1'b0;

      pen_x_in     = pen_x_ff;
      pen_y_in     = pen_y_ff;
      color_in     = color_ff;
      tilde_in     = tilde_ff;
      glyph_in     = glyph_ff;
      draw_x_in    = draw_x_ff;
      draw_y_in    = draw_y_ff;
      out_color_in = out_color_ff;
      rsp_valid_in = rsp_valid_ff && !ready;

      if (advance) begin
         tilde_in = 1'b0;
         if (tilde_ff && !item.sot) begin
            if (item.slot_ok) begin
               col = item.slot_zero ? cfg.base_color : item.pal_color;
            end else begin
               plain = 1'b1;
            end
         end else if (item.is_tilde && !item.last) begin
            tilde_in = 1'b1;
         end else begin
            plain = 1'b1;
         end

         if (plain) begin
            if (item.is_newline) begin
               py = py + 16'(cfg.line_height);
               px = cfg.origin_x;
            end else if (item.hit) begin
               emit         = 1'b1;
               glyph_in     = item.glyph;
               draw_x_in    = px - 16'(rd_offset);
               draw_y_in    = py;
               out_color_in = col;
               px           = px + 16'(rd_width) + kern_ext;
            end else begin
               px = px + 16'(cfg.cell_width) + kern_ext;
            end
         end

         pen_x_in     = px;
         pen_y_in     = py;
         color_in     = col;
         rsp_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff     <= 16'h0000;
         pen_y_ff     <= 16'h0000;
         color_ff     <= 32'hffffffff;
         tilde_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
         color_ff     <= color_in;
         tilde_ff     <= tilde_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      glyph_ff     <= glyph_in;
      draw_x_ff    <= draw_x_in;
      draw_y_ff    <= draw_y_in;
      out_color_ff <= out_color_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_glyph  = glyph_ff;
   assign rsp_draw_x = draw_x_ff;
   assign rsp_draw_y = draw_y_ff;
   assign rsp_color  = out_color_ff;

endmodule

// ----- rtl/core/bitmap_text_layout.sv -----
`timescale 1ns / 1ps
// Text layout for bitmap fonts. Characters and glyph table loads arrive as beats
// on the req_ channel; draw commands leave as beats on the rsp_ channel.
// req_mode 1 writes one entry of the glyph width/offset table and yields no
// beat; req_mode 0 feeds one text character, which yields zero or one draw
// command (glyph index, draw position, RGBA tint).
// Throughput: one beat per cycle in steady state while rsp_stall is low. A text
// character performs its glyph table read at acceptance and is registered into
// the decode stage; the pen stage then updates the pen and registers the draw
// command that is presented on rsp_.
// A table write and a character read in back-to-back cycles need no bubble.
// The csr_ port writes one configuration register per enabled cycle; write it
// only when the block is idle.
// Reset restores the configuration defaults, the pen to zero, the color to
// all ones, clears the tilde flag and drops any beat in flight. The glyph
// table is not cleared and must be loaded before the entries are used.
// When rsp_stall is high with a draw command waiting, the pen stage holds
// and req_stall rises once the next character is queued behind it.
module bitmap_text_layout
   import btl_pkg::*;
#(
   parameter int GLYPHS     = 256,
   parameter int WIDTH_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  logic [7:0]         req_code,
   input  logic               req_start_of_text,
   input  logic               req_end_of_text,
   input  logic [7:0]         req_entry_index,
   input  logic [7:0]         req_entry_width,
   input  logic [7:0]         req_entry_offset,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_glyph,
   output logic signed [15:0] rsp_draw_x,
   output logic signed [15:0] rsp_draw_y,
   output logic [31:0]        rsp_color,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wr_data
);

   localparam int         IDX_W       = (GLYPHS > 1) ? $clog2(GLYPHS) : 1;
   localparam logic [8:0] GLYPH_LIMIT = 9'(GLYPHS);

   cfg_type  cfg_ff, cfg_in;
   logic     s1_valid_ff, s1_valid_in;
   char_type s1_ff;
   char_type dec;

   logic                  req_accept;
   logic                  pen_ready;
   logic [7:0]            idx;
   logic                  wr_en;
   logic                  rd_en;
   logic [WIDTH_BITS-1:0] rd_width;
   logic [WIDTH_BITS-1:0] rd_offset;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ORIGIN_X:    cfg_in.origin_x    = csr_wr_data[15:0];
            CSR_ORIGIN_Y:    cfg_in.origin_y    = csr_wr_data[15:0];
            CSR_BASE_COLOR:  cfg_in.base_color  = csr_wr_data;
            CSR_FIRST_CODE:  cfg_in.first_code  = csr_wr_data[7:0];
            CSR_GLYPH_COUNT: cfg_in.glyph_count = csr_wr_data[8:0];
            CSR_LINE_HEIGHT: cfg_in.line_height = csr_wr_data[7:0];
            CSR_CELL_WIDTH:  cfg_in.cell_width  = csr_wr_data[7:0];
            CSR_KERN:        cfg_in.kern        = csr_wr_data[7:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   assign req_stall  = s1_valid_ff && !pen_ready;
   assign req_accept = req_valid && !req_stall;
   assign idx        = req_code - cfg_ff.first_code;

   // Decode the character: escape class, palette pick and table hit.
   always_comb begin
      dec.sot        = req_start_of_text;
      dec.last       = req_end_of_text;
      dec.is_newline = (req_code == CHAR_NEWLINE);
      dec.is_tilde   = (req_code == CHAR_TILDE);
      dec.slot_ok    = slot_valid(req_code);
      dec.slot_zero  = (slot_of(req_code) == 6'd0);
      dec.pal_color  = dec.slot_ok ? PALETTE[slot_of(req_code)] : 32'h0;
      dec.hit        = (req_code >= cfg_ff.first_code) &&
                       ({1'b0, idx} < cfg_ff.glyph_count) &&
                       ({1'b0, idx} < GLYPH_LIMIT);
      dec.glyph      = idx;
   end

   assign wr_en = req_accept && req_mode && ({1'b0, req_entry_index} < GLYPH_LIMIT);
   assign rd_en = req_accept && !req_mode;

   always_comb begin
      if (req_accept) begin
         s1_valid_in = !req_mode;
      end else begin
         s1_valid_in = s1_valid_ff && !pen_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= CFG_RESET;
         s1_valid_ff <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_ff <= dec;
      end
   end

   btl_glyph_mem #(
      .GLYPHS     (GLYPHS),
      .WIDTH_BITS (WIDTH_BITS),
      .IDX_W      (IDX_W)
   ) u_glyph_mem (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (req_entry_index[IDX_W-1:0]),
      .wr_width  (WIDTH_BITS'(req_entry_width)),
      .wr_offset (WIDTH_BITS'(req_entry_offset)),
      .rd_en     (rd_en),
      .rd_addr   (idx[IDX_W-1:0]),
      .rd_width  (rd_width),
      .rd_offset (rd_offset)
   );

   btl_pen #(
      .WIDTH_BITS (WIDTH_BITS)
   ) u_pen (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (s1_valid_ff),
      .item       (s1_ff),
      .rd_width   (rd_width),
      .rd_offset  (rd_offset),
      .ready      (pen_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_glyph  (rsp_glyph),
      .rsp_draw_x (rsp_draw_x),
      .rsp_draw_y (rsp_draw_y),
      .rsp_color  (rsp_color)
   );

endmodule

// ----- rtl/core/btl_checker.sv -----
`timescale 1ns / 1ps
`include "bitmap_text_layout_defines.svh"
module btl_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [7:0]         rsp_glyph,
   input logic signed [15:0] rsp_draw_x,
   input logic signed [15:0] rsp_draw_y,
   input logic [31:0]        rsp_color
);

   logic [71:0] rsp_payload;

   assign rsp_payload = {rsp_glyph, rsp_draw_x, rsp_draw_y, rsp_color};

   // Input backpressure only ever comes from a blocked result.
   `BTL_ASSERT_IMP(a_stall_from_rsp, clock, reset, req_stall, rsp_valid && rsp_stall)

   `BTL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   `BTL_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_payload))

   // Reset drops any beat in flight and frees the input.
   `BTL_ASSERT_NEXT_ALWAYS(a_reset_flush, clock, reset, !rsp_valid && !req_stall)

endmodule

bind bitmap_text_layout btl_checker u_btl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_glyph  (rsp_glyph),
   .rsp_draw_x (rsp_draw_x),
   .rsp_draw_y (rsp_draw_y),
   .rsp_color  (rsp_color)
);
